[rtl/core/mixing_length_eddy_diffusivity_top_defines.svh]
// Assertion macros for the mixing-length eddy diffusivity block
`ifndef MIXING_LENGTH_EDDY_DIFFUSIVITY_TOP_DEFINES_SVH
`define MIXING_LENGTH_EDDY_DIFFUSIVITY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MLD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
`define MLD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define MLD_ASSERT(lbl, cond)
`define MLD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[rtl/core/mld_pkg.sv]
// Types and constants shared by the eddy diffusivity pipeline
`default_nettype none
package mld_pkg;
  localparam int FRAC_BITS = 16;
  localparam int INV_FRAC  = 16;
  localparam int GRAD_W    = 32;
  localparam int INV_W     = 24;
  localparam int OUT_W     = 48;
  localparam int SUM_W     = 68;
  localparam int ROOT_W    = 35;
  localparam int LL_W      = 64;
  localparam int NI_W      = ROOT_W + INV_W;
  localparam int PROD_W    = NI_W + LL_W;
  localparam int OUT_SHIFT = 2 * FRAC_BITS + INV_FRAC;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCHMIDT = 2'd1;
  localparam logic [1:0]  DIMS_RESET = 2'd3;
  localparam logic [INV_W-1:0] INV_RESET = 24'd93623;

  typedef struct packed {
    logic signed [GRAD_W-1:0] du_dx;
    logic signed [GRAD_W-1:0] du_dy;
    logic signed [GRAD_W-1:0] du_dz;
    logic signed [GRAD_W-1:0] dv_dx;
    logic signed [GRAD_W-1:0] dv_dy;
    logic signed [GRAD_W-1:0] dv_dz;
    logic signed [GRAD_W-1:0] dw_dx;
    logic signed [GRAD_W-1:0] dw_dy;
    logic signed [GRAD_W-1:0] dw_dz;
    logic [GRAD_W-1:0]        mix_len;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] diffusivity;
    logic             saturated;
  } out_t;
endpackage
`default_nettype wire

[rtl/core/mixing_length_eddy_diffusivity_top.sv]
// Pipeline: strain stages, then square-root stages, then product stages, from input accept to output valid.
// Throughput: one item per clock; the pipeline advances as one unit and holds
// everything in place while the output item waits to be taken.
// Reset: asynchronous active low; clears all stage valid bits and loads
// dimensions = 3 and inv_schmidt = 93623.
`default_nettype none
`include "mixing_length_eddy_diffusivity_top_defines.svh"
module mixing_length_eddy_diffusivity_top import mld_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [INV_W-1:0]     cfg_wdata_i
);
  logic              en;
  logic [1:0]        dims_q;
  logic [INV_W-1:0]  inv_q;
  logic              s_vld, r_vld;
  logic [SUM_W-1:0]  s_sum;
  logic [LL_W-1:0]   s_ll, r_ll;
  logic [ROOT_W-1:0] r_root;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_RESET;
      inv_q  <= INV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIMENSIONS:  dims_q <= cfg_wdata_i[1:0];
        CFG_INV_SCHMIDT: inv_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mld_strain u_strain (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .data_i(in_data_i),
    .dims_i(dims_q), .vld_o(s_vld), .sum_o(s_sum), .ll_o(s_ll)
  );

  mld_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_vld), .sum_i(s_sum), .ll_i(s_ll),
    .vld_o(r_vld), .root_o(r_root), .ll_o(r_ll)
  );

  mld_mul u_mul (
    .clk_i, .rst_ni, .en_i(en), .vld_i(r_vld), .root_i(r_root), .ll_i(r_ll),
    .inv_i(inv_q), .vld_o(out_valid_o), .data_o(out_data_o)
  );

  `MLD_ASSERT(a_sat_max, !(out_valid_o && out_data_o.saturated) || (&out_data_o.diffusivity))
  `MLD_ASSERT_NEXT(a_fill, in_valid_i && in_ready_o, u_strain.vld_q[0])
endmodule
`default_nettype wire

[rtl/core/mld_strain.sv]
// Strain-rate sum and squared mixing length, three stages
`default_nettype none
module mld_strain import mld_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire in_t              data_i,
  input  wire logic [1:0]       dims_i,
  output logic                  vld_o,
  output logic [SUM_W-1:0]      sum_o,
  output logic [LL_W-1:0]       ll_o
);
  localparam int MAG_W = GRAD_W + 1;
  localparam int DSQ_W = 2 * GRAD_W;
  localparam int PSQ_W = 2 * MAG_W;

  function automatic logic [GRAD_W-1:0] mag1(input logic signed [GRAD_W-1:0] a);
    logic signed [MAG_W-1:0] e;
    e = {a[GRAD_W-1], a};
    return e[MAG_W-1] ? GRAD_W'(-e) : GRAD_W'(e);
  endfunction

  function automatic logic [MAG_W-1:0] mag2(input logic signed [GRAD_W-1:0] a,
                                            input logic signed [GRAD_W-1:0] b);
    logic signed [MAG_W:0] s;
    s = {{2{a[GRAD_W-1]}}, a} + {{2{b[GRAD_W-1]}}, b};
    return s[MAG_W] ? MAG_W'(-s) : MAG_W'(s);
  endfunction

  logic use2, use3;
  logic [GRAD_W-1:0] m0, m1, m2;
  logic [MAG_W-1:0]  n0, n1, n2;
  logic [2:0] vld_q;
  logic [DSQ_W-1:0] d0_q, d1_q, d2_q;
  logic [PSQ_W-1:0] p0_q, p1_q, p2_q;
  logic [LL_W-1:0]  ll1_q, ll2_q, ll3_q;
  logic [DSQ_W+1:0] dsum_q;
  logic [PSQ_W+1:0] psum_q;
  logic [SUM_W-1:0] sum_q;

  // dimensions zero acts as one
  assign use2 = dims_i[1];
  assign use3 = dims_i[1] & dims_i[0];
  assign m0 = mag1(data_i.du_dx);
  assign m1 = use2 ? mag1(data_i.dv_dy) : '0;
  assign m2 = use3 ? mag1(data_i.dw_dz) : '0;
  assign n0 = use2 ? mag2(data_i.dv_dx, data_i.du_dy) : '0;
  assign n1 = use3 ? mag2(data_i.du_dz, data_i.dw_dx) : '0;
  assign n2 = use3 ? mag2(data_i.dv_dz, data_i.dw_dy) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_q   <= m0 * m0;
      d1_q   <= m1 * m1;
      d2_q   <= m2 * m2;
      p0_q   <= n0 * n0;
      p1_q   <= n1 * n1;
      p2_q   <= n2 * n2;
      ll1_q  <= data_i.mix_len * data_i.mix_len;
      dsum_q <= (DSQ_W+2)'(d0_q) + (DSQ_W+2)'(d1_q) + (DSQ_W+2)'(d2_q);
      psum_q <= (PSQ_W+2)'(p0_q) + (PSQ_W+2)'(p1_q) + (PSQ_W+2)'(p2_q);
      ll2_q  <= ll1_q;
      sum_q  <= SUM_W'({dsum_q, 1'b0}) + SUM_W'(psum_q);
      ll3_q  <= ll2_q;
    end
  end

  assign vld_o = vld_q[2];
  assign sum_o = sum_q;
  assign ll_o  = ll3_q;
endmodule
`default_nettype wire

[rtl/core/mld_sqrt.sv]
// Integer square root, one result bit per pipeline stage
`default_nettype none
module mld_sqrt import mld_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [SUM_W-1:0]  sum_i,
  input  wire logic [LL_W-1:0]   ll_i,
  output logic                   vld_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [LL_W-1:0]        ll_o
);
  localparam int TW = 2 * ROOT_W;

  logic [SUM_W-1:0]  rem_s  [ROOT_W+1];
  logic [ROOT_W-1:0] root_s [ROOT_W+1];
  logic [LL_W-1:0]   ll_s   [ROOT_W+1];
  logic              vld_s  [ROOT_W+1];

  assign rem_s[0]  = sum_i;
  assign root_s[0] = '0;
  assign ll_s[0]   = ll_i;
  assign vld_s[0]  = vld_i;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_st
    localparam int K = ROOT_W - 1 - i;
    logic [TW-1:0]     trial;
    logic              take;
    logic [SUM_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;
    logic [LL_W-1:0]   ll_q;
    logic              vld_q;

    // trial = 2*root*2^K + 2^(2K)
    assign trial = (TW'(root_s[i]) << (K + 1)) | (TW'(1) << (2 * K));
    assign take  = trial <= TW'(rem_s[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= take ? rem_s[i] - trial[SUM_W-1:0] : rem_s[i];
        root_q <= take ? root_s[i] | (ROOT_W'(1) << K) : root_s[i];
        ll_q   <= ll_s[i];
      end
    end

    assign rem_s[i+1]  = rem_q;
    assign root_s[i+1] = root_q;
    assign ll_s[i+1]   = ll_q;
    assign vld_s[i+1]  = vld_q;
  end

  assign vld_o  = vld_s[ROOT_W];
  assign root_o = root_s[ROOT_W];
  assign ll_o   = ll_s[ROOT_W];
endmodule
`default_nettype wire

[rtl/core/mld_mul.sv]
// Norm times mixing length squared times 1/Sc, with output saturation
`default_nettype none
module mld_mul import mld_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [ROOT_W-1:0] root_i,
  input  wire logic [LL_W-1:0]   ll_i,
  input  wire logic [INV_W-1:0]  inv_i,
  output logic                   vld_o,
  output out_t                   data_o
);
  localparam int NL_W = 30;
  localparam int NH_W = NI_W - NL_W;
  localparam int LH_W = LL_W / 2;

  logic [3:0]          vld_q;
  logic [NI_W-1:0]     ni_q;
  logic [LL_W-1:0]     ll_q;
  logic [NL_W+LH_W-1:0] pp0_q, pp1_q;
  logic [NH_W+LH_W-1:0] pp2_q, pp3_q;
  logic [NL_W+LH_W-1:0] lo_q;
  logic [NL_W+LH_W+2:0] mid_q;
  logic [NH_W+LH_W-1:0] hi_q;
  logic [PROD_W-1:0]   prod;
  logic                sat;
  out_t                out_q;

  // mid_q carries weight 2^NL_W; pp1 sits LH_W - NL_W bits above pp2
  assign prod = PROD_W'(lo_q) + (PROD_W'(mid_q) << NL_W) + (PROD_W'(hi_q) << (NL_W + LH_W));
  assign sat  = |prod[PROD_W-1:OUT_SHIFT+OUT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ni_q  <= root_i * inv_i;
      ll_q  <= ll_i;
      pp0_q <= ni_q[NL_W-1:0] * ll_q[LH_W-1:0];
      pp1_q <= ni_q[NL_W-1:0] * ll_q[LL_W-1:LH_W];
      pp2_q <= ni_q[NI_W-1:NL_W] * ll_q[LH_W-1:0];
      pp3_q <= ni_q[NI_W-1:NL_W] * ll_q[LL_W-1:LH_W];
      lo_q  <= pp0_q;
      mid_q <= ((NL_W+LH_W+3)'(pp1_q) << (LH_W - NL_W)) + (NL_W+LH_W+3)'(pp2_q);
      hi_q  <= pp3_q;
      out_q.saturated   <= sat;
      out_q.diffusivity <= sat ? '1 : prod[OUT_SHIFT+OUT_W-1:OUT_SHIFT];
    end
  end

  assign vld_o  = vld_q[3];
  assign data_o = out_q;
endmodule
`default_nettype wire

[bench/mixing_length_eddy_diffusivity_top_test.sv]
// Self-checking testbench for the mixing-length eddy diffusivity pipeline
`default_nettype none
module mixing_length_eddy_diffusivity_top_test;
  import mld_pkg::*;

  localparam int N_DIRECTED = 14;
  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int STALL_LIMIT = 3000;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_DIMENSIONS;
  logic [INV_W-1:0] cfg_wdata_i = '0;

  mixing_length_eddy_diffusivity_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the configuration
  logic [1:0]       dims_q = DIMS_RESET;
  logic [INV_W-1:0] inv_sc_q = INV_RESET;

  out_t expected_diffusivity[$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   saturated_seen = 0;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;
  // typed-in expectation for the next accepted item, if any
  bit   use_typed = 1'b0;
  out_t typed_result = '0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [67:0] diag_sq(input logic signed [31:0] a);
    logic signed [33:0] s;
    logic [33:0] m;
    s = a;
    m = s[33] ? -s : s;
    return ({34'd0, m} * {34'd0, m}) << 1;
  endfunction

  function automatic logic [67:0] pair_sq(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [33:0] s;
    logic [33:0] m;
    s = $signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b});
    m = s[33] ? -s : s;
    return {34'd0, m} * {34'd0, m};
  endfunction

  function automatic out_t predict_diffusivity(input in_t x);
    logic [67:0]  strain;
    logic [34:0]  root;
    logic [34:0]  trial;
    logic [69:0]  sq;
    logic [127:0] prod;
    logic [79:0]  scaled;
    out_t r;
    strain = diag_sq(x.du_dx);
    // zero dimensions behaves as one
    if (dims_q >= 2) begin
      strain = strain + diag_sq(x.dv_dy) + pair_sq(x.dv_dx, x.du_dy);
      if (dims_q == 3)
        strain = strain + diag_sq(x.dw_dz) + pair_sq(x.du_dz, x.dw_dx)
                 + pair_sq(x.dv_dz, x.dw_dy);
    end
    root = '0;
    for (int k = 34; k >= 0; k--) begin
      trial = root | (35'd1 << k);
      sq = {35'd0, trial} * {35'd0, trial};
      if (sq <= {2'b00, strain}) root = trial;
    end
    prod = 128'(root) * 128'(x.mix_len) * 128'(x.mix_len) * 128'(inv_sc_q);
    scaled = 80'(prod >> OUT_SHIFT);
    if (scaled > 80'(OUT_MAX)) begin
      r.diffusivity = OUT_MAX;
      r.saturated = 1'b1;
    end else begin
      r.diffusivity = scaled[OUT_W-1:0];
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  // input side monitor: record expectation when an item is taken
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (use_typed) expected_diffusivity.push_back(typed_result);
      else expected_diffusivity.push_back(predict_diffusivity(in_data_i));
      items_sent++;
    end
  end

  // output side checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_data_o.saturated) saturated_seen++;
      if (expected_diffusivity.size() == 0) begin
        report("unexpected item", 64'(out_data_o), 64'd0);
      end else begin
        want = expected_diffusivity.pop_front();
        if (out_data_o.diffusivity !== want.diffusivity)
          report("diffusivity", 64'(out_data_o.diffusivity),
                 64'(want.diffusivity));
        if (out_data_o.saturated !== want.saturated)
          report("saturated", 64'(out_data_o.saturated), 64'(want.saturated));
      end
    end
  end

  // receiver stalls in bursts
  int rx_stall = 0;
  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_ready_i <= 1'b1;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      rx_stall = $urandom_range(1, 15) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog: cycles with no handshake on either channel and no config write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input in_t x);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_diffusivity.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [INV_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_DIMENSIONS) dims_q = val[1:0];
    else if (idx == CFG_INV_SCHMIDT) inv_sc_q = val;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_grad();
    logic [31:0] g;
    case ($urandom_range(0, 4))
      0: g = $urandom;
      1, 2: begin
        g = $urandom & 32'h001F_FFFF;
        if ($urandom_range(0, 1)) g = -g;
      end
      3: g = '0;
      default: g = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
    return g;
  endfunction

  function automatic in_t rand_item();
    in_t x;
    x.du_dx = rand_grad(); x.du_dy = rand_grad(); x.du_dz = rand_grad();
    x.dv_dx = rand_grad(); x.dv_dy = rand_grad(); x.dv_dz = rand_grad();
    x.dw_dx = rand_grad(); x.dw_dy = rand_grad(); x.dw_dz = rand_grad();
    case ($urandom_range(0, 3))
      0: x.mix_len = $urandom;
      3: x.mix_len = $urandom & 32'h0000_FFFF;
      default: x.mix_len = $urandom & 32'h0003_FFFF;
    endcase
    return x;
  endfunction

  in_t  dir_item [N_DIRECTED];
  bit   dir_typed[N_DIRECTED];
  out_t dir_result[N_DIRECTED];

  // phase settings: dimensions, inverse Schmidt
  logic [1:0]       phase_dims[N_PHASES] = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd3, 2'd2, 2'd1, 2'd3};
  logic [INV_W-1:0] phase_inv [N_PHASES] = '{24'd1, 24'hFFFFFF, 24'd93623, 24'd0,
                                             24'hFFFFFF, 24'd1, 24'd65536, 24'd93623};

  initial begin
    dir_item = '{default: '0};
    dir_typed = '{default: 1'b0};
    dir_result = '{default: '0};
    dir_typed[0] = 1'b1;                                             // all zero
    dir_item[1] = {{9{32'h7FFF_FFFF}}, 32'h0};  dir_typed[1] = 1'b1;  // no length
    dir_item[2] = {{9{32'h8000_0000}}, 32'hFFFF_FFFF}; dir_typed[2] = 1'b1;
    dir_result[2] = {OUT_MAX, 1'b1};
    dir_item[3] = {{9{32'h7FFF_FFFF}}, 32'hFFFF_FFFF}; dir_typed[3] = 1'b1;
    dir_result[3] = {OUT_MAX, 1'b1};
    dir_item[4] = {32'h0001_0000, {8{32'h0}}, 32'h0001_0000};
    dir_item[5] = {{9{32'h5555_5555}}, 32'hAAAA_AAAA};
    dir_item[6] = {{9{32'hAAAA_AAAA}}, 32'h5555_5555};
    // opposite off-diagonal pairs cancel
    dir_item[7] = {32'h0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0,
                   32'h0003_0000, 32'hFFFE_0000, 32'hFFFD_0000, 32'h0, 32'h0004_0000};
    dir_item[8] = {32'hFFFF_FFFF, {8{32'h0000_0001}}, 32'h0000_0001};
    dir_item[9] = {{9{32'h0000_0001}}, 32'hFFFF_FFFF};
    dir_item[10] = {32'h8000_0000, {8{32'h0}}, 32'h0001_0000};
    dir_item[11] = {{4{32'h0}}, 32'h8000_0000, {3{32'h0}}, 32'h8000_0000, 32'h0100_0000};
    dir_item[12] = {{9{32'hFFFF_0000}}, 32'h0010_0000};
    dir_item[13] = {32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                    {3{32'h7FFF_FFFF}}, 32'h0, 32'h0000_8000};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset settings; the typed flag changes with the item
    for (int i = 0; i < N_DIRECTED; i++) begin
      use_typed <= dir_typed[i];
      typed_result <= dir_result[i];
      send_item(dir_item[i]);
    end
    use_typed <= 1'b0;
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      cfg_write(CFG_DIMENSIONS, 24'(phase_dims[p]));
      cfg_write(CFG_INV_SCHMIDT, phase_inv[p]);
      if (p == 0) begin
        // out-of-range indexes must leave both registers alone
        cfg_write(2'd2, 24'h000000);
        cfg_write(2'd3, 24'hFFFFFF);
      end
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      if (p == N_PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(rand_item());
      drain();
    end

    $display("covered %0d items over %0d settings, %0d results, %0d saturated",
             items_sent, N_PHASES + 1, results_seen, saturated_seen);
    $display("dimensions 0..3 and inverse Schmidt 0..max with random stalls on both sides");
    if (mismatches == 0 && expected_diffusivity.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
